### rtl/lrukl_pkg.sv
// ----------------------------------------------------------------------------
// LRU key list package
// Function codes, the memory control bundle between the sequencer and the key
// store, and the result bundle between the sequencer and the output register.
// ----------------------------------------------------------------------------
package lrukl_pkg;

    // Function codes carried by the input func field.
    localparam logic [2:0] FUNC_PUT       = 3'd0;
    localparam logic [2:0] FUNC_HIT       = 3'd1;
    localparam logic [2:0] FUNC_REMOVE    = 3'd2;
    localparam logic [2:0] FUNC_REMOVE_AT = 3'd3;
    localparam logic [2:0] FUNC_READ_AT   = 3'd4;
    localparam logic [2:0] FUNC_CLEAR     = 3'd5;

    // Source of the data written into the key store.
    typedef enum logic [1:0] {
        WR_KEY   = 2'd0,
        WR_RDATA = 2'd1,
        WR_HOLD  = 2'd2
    } t_wr_src;

    // Control from the sequencer to the key store.
    typedef struct packed {
        logic    rd_en;
        logic    wr_en;
        t_wr_src wr_src;
        logic    load_key;
        logic    capture;
    } t_mem_ctl;

    // One result handed from the sequencer to the output register.
    typedef struct packed {
        logic valid;
        logic ok;
        logic freed;
        logic rd;
        logic last;
    } t_emit;

endpackage

### rtl/lru_ordered_key_list_top.sv
// ----------------------------------------------------------------------------
// LRU ordered key list, top level
// Keeps keys ordered from oldest to most recently used, with put, hit,
// remove, remove/read at position and clear, on a shared memory port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries func, key and position.
//   Output channel (o_out_valid / i_out_ready) carries one result per
//   transfer; a clear of a non-empty list gives one result per key, and
//   o_last marks the final result of each item.
//   i_cfg_we writes max_entries from i_cfg_data; 0 selects the full depth.
//   Timing is set by the single memory port, one access per cycle while no
//   result waits on the output. An item is decoded, then reads entries
//   (searched, taken or read at a position), moves entries to close a gap,
//   appends for a put or hit, and reports its result; a clear reads back
//   and reports every key in turn.
//   The block accepts one item at a time; o_in_ready returns once the last
//   result is in the output register, so the next item can start while that
//   result still waits.
//   A stalled receiver holds the output register and the sequencer waits
//   before issuing the next result.
//   Synchronous active-low reset empties the list and sets max_entries to 0.
// ----------------------------------------------------------------------------
module lru_ordered_key_list_top #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [31:0] i_key,
    input  logic [3:0]  i_position,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_ok,
    output logic        o_freed_valid,
    output logic [31:0] o_freed_key,
    output logic [31:0] o_read_key,
    output logic [4:0]  o_count,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lrukl_pkg::t_mem_ctl  mem_ctl;
    lrukl_pkg::t_emit     emit;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 match;
    logic [KEY_WIDTH-1:0] hold;
    logic [CW-1:0]        count;
    logic                 out_free;

    logic [4:0]  r_max_entries;
    logic        r_out_valid;
    logic        r_ok;
    logic        r_freed_valid;
    logic [31:0] r_freed_key;
    logic [31:0] r_read_key;
    logic [4:0]  r_count;
    logic        r_last;

    assign out_free = !r_out_valid || i_out_ready;

    lrukl_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_position    (i_position),
        .i_max_entries (r_max_entries),
        .i_match       (match),
        .i_out_free    (out_free),
        .o_ctl         (mem_ctl),
        .o_rd_addr     (rd_addr),
        .o_wr_addr     (wr_addr),
        .o_emit        (emit),
        .o_count       (count)
    );

    lrukl_store #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (mem_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_key     (KEY_WIDTH'(i_key)),
        .o_match   (match),
        .o_hold    (hold)
    );

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= '0;
        end else if (i_cfg_we) begin
            r_max_entries <= i_cfg_data;
        end
    end

    // Output register valid: set on a new result, cleared by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; keys not reported read as zero.
    always_ff @(posedge i_clk) begin
        if (emit.valid) begin
            r_ok          <= emit.ok;
            r_freed_valid <= emit.freed;
            r_freed_key   <= emit.freed ? 32'(hold) : 32'd0;
            r_read_key    <= emit.rd ? 32'(hold) : 32'd0;
            r_count       <= 5'(count);
            r_last        <= emit.last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_freed_valid = r_freed_valid;
    assign o_freed_key   = r_freed_key;
    assign o_read_key    = r_read_key;
    assign o_count       = r_count;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    // Results wait in the output register until the receiver takes them.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result dropped while stalled");

    // The limit register follows every configuration write.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_max_entries == $past(i_cfg_data)))
        else $error("configuration write lost");

    // A freed flag never comes with a read key.
    a_freed_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_freed_valid && (o_read_key != 32'd0)))
        else $error("freed result carries a read key");
`endif

endmodule

### rtl/lrukl_store.sv
// ----------------------------------------------------------------------------
// LRU key list store
// Key memory with a registered read port, the item key register, the hold
// register for a key taken out of the list, and the shared key comparator.
// ----------------------------------------------------------------------------
module lrukl_store #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                     i_clk,
    input  lrukl_pkg::t_mem_ctl      i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [KEY_WIDTH-1:0]     i_key,
    output logic                     o_match,
    output logic [KEY_WIDTH-1:0]     o_hold
);

    logic [KEY_WIDTH-1:0] r_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_rd_data;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_hold;
    logic [KEY_WIDTH-1:0] wr_data;

    // Write data selection: new key, key just read (shift), or held key.
    always_comb begin
        case (i_ctl.wr_src)
            lrukl_pkg::WR_KEY:   wr_data = r_key;
            lrukl_pkg::WR_RDATA: wr_data = r_rd_data;
            lrukl_pkg::WR_HOLD:  wr_data = r_hold;
            default:             wr_data = r_key;
        endcase
    end

    // Memory with one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Item key and hold registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_key) begin
            r_key <= i_key;
        end
        if (i_ctl.capture) begin
            r_hold <= r_rd_data;
        end
    end

    // Shared comparator against the entry read in the previous cycle.
    assign o_match = (r_rd_data == r_key);
    assign o_hold  = r_hold;

endmodule

### rtl/lrukl_seq.sv
// ----------------------------------------------------------------------------
// LRU key list sequencer
// Steps one operation through search, gap closing, append and result issue,
// one memory access per cycle, and keeps the entry count.
// ----------------------------------------------------------------------------
module lrukl_seq #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [2:0]                 i_func,
    input  logic [3:0]                 i_position,
    input  logic [4:0]                 i_max_entries,
    input  logic                       i_match,
    input  logic                       i_out_free,
    output lrukl_pkg::t_mem_ctl        o_ctl,
    output logic [$clog2(DEPTH)-1:0]   o_rd_addr,
    output logic [$clog2(DEPTH)-1:0]   o_wr_addr,
    output lrukl_pkg::t_emit           o_emit,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_LOOK   = 9'b000000100,
        S_TEST   = 9'b000001000,
        S_SH_RD  = 9'b000010000,
        S_SH_WR  = 9'b000100000,
        S_APPEND = 9'b001000000,
        S_EMIT   = 9'b010000000,
        S_SPARE  = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [2:0]    r_func, n_func;
    logic [3:0]    r_pos, n_pos;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_count, n_count;
    logic          r_ok, n_ok;
    logic          r_fv, n_fv;
    logic          r_rd, n_rd;

    logic [CW-1:0]   i_next;
    logic [CMPW-1:0] cnt_x;
    logic [CMPW-1:0] max_x;
    logic [CMPW-1:0] dep_x;
    logic            evict;
    logic            pos_ok;
    logic            searching;
    logic            emit_last;

    // Comparisons that decide eviction and position range.
    assign i_next    = r_i + CW'(1);
    assign cnt_x     = CMPW'(r_count);
    assign max_x     = CMPW'(i_max_entries);
    assign dep_x     = CMPW'(DEPTH);
    assign evict     = (cnt_x >= dep_x)
                     || ((max_x != '0) && (max_x <= dep_x) && (cnt_x == max_x));
    assign pos_ok    = (CMPW'(r_pos) < cnt_x);
    assign searching = (r_func == lrukl_pkg::FUNC_HIT) || (r_func == lrukl_pkg::FUNC_REMOVE);
    assign emit_last = (r_func != lrukl_pkg::FUNC_CLEAR) || !r_fv || (i_next == r_n);

    // Next state and memory control.
    always_comb begin
        n_state   = r_state;
        n_func    = r_func;
        n_pos     = r_pos;
        n_i       = r_i;
        n_n       = r_n;
        n_count   = r_count;
        n_ok      = r_ok;
        n_fv      = r_fv;
        n_rd      = r_rd;
        o_ctl     = '0;
        o_rd_addr = r_i[AW-1:0];
        o_wr_addr = r_i[AW-1:0];
        o_emit    = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load_key = i_in_valid;
                if (i_in_valid) begin
                    n_func  = i_func;
                    n_pos   = i_position;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_ok    = 1'b0;
                n_fv    = 1'b0;
                n_rd    = 1'b0;
                n_i     = '0;
                n_state = S_EMIT;
                unique case (r_func) inside
                    lrukl_pkg::FUNC_PUT: begin
                        n_ok = 1'b1;
                        if (evict) begin
                            n_fv    = 1'b1;
                            n_state = S_LOOK;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end
                    lrukl_pkg::FUNC_HIT, lrukl_pkg::FUNC_REMOVE: begin
                        if (r_count != '0) begin
                            n_state = S_LOOK;
                        end
                    end
                    lrukl_pkg::FUNC_REMOVE_AT, lrukl_pkg::FUNC_READ_AT: begin
                        if (pos_ok) begin
                            n_i     = CW'(r_pos);
                            n_state = S_LOOK;
                        end
                    end
                    lrukl_pkg::FUNC_CLEAR: begin
                        n_ok    = 1'b1;
                        n_n     = r_count;
                        n_count = '0;
                        if (r_count != '0) begin
                            n_fv    = 1'b1;
                            n_state = S_LOOK;
                        end
                    end
                    default: ;
                endcase
            end
            S_LOOK: begin
                o_ctl.rd_en = 1'b1;
                o_rd_addr   = r_i[AW-1:0];
                n_state     = S_TEST;
            end
            S_TEST: begin
                o_ctl.capture = 1'b1;
                if (searching && !i_match) begin
                    if (i_next == r_count) begin
                        n_state = S_EMIT;
                    end else begin
                        n_i     = i_next;
                        n_state = S_LOOK;
                    end
                end else begin
                    unique case (r_func) inside
                        lrukl_pkg::FUNC_HIT: begin
                            n_ok    = 1'b1;
                            n_state = S_SH_RD;
                        end
                        lrukl_pkg::FUNC_REMOVE, lrukl_pkg::FUNC_REMOVE_AT: begin
                            n_ok    = 1'b1;
                            n_fv    = 1'b1;
                            n_state = S_SH_RD;
                        end
                        lrukl_pkg::FUNC_READ_AT: begin
                            n_ok    = 1'b1;
                            n_rd    = 1'b1;
                            n_state = S_EMIT;
                        end
                        lrukl_pkg::FUNC_PUT: begin
                            n_state = S_SH_RD;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_SH_RD: begin
                if (i_next < r_count) begin
                    o_ctl.rd_en = 1'b1;
                    o_rd_addr   = i_next[AW-1:0];
                    n_state     = S_SH_WR;
                end else begin
                    n_count = r_count - CW'(1);
                    if ((r_func == lrukl_pkg::FUNC_PUT) || (r_func == lrukl_pkg::FUNC_HIT)) begin
                        n_state = S_APPEND;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SH_WR: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_src = lrukl_pkg::WR_RDATA;
                o_wr_addr    = r_i[AW-1:0];
                n_i          = i_next;
                n_state      = S_SH_RD;
            end
            S_APPEND: begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_src = (r_func == lrukl_pkg::FUNC_PUT) ? lrukl_pkg::WR_KEY
                                                               : lrukl_pkg::WR_HOLD;
                o_wr_addr    = r_count[AW-1:0];
                n_count      = r_count + CW'(1);
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_out_free) begin
                    o_emit.valid = 1'b1;
                    o_emit.ok    = r_ok;
                    o_emit.freed = r_fv;
                    o_emit.rd    = r_rd;
                    o_emit.last  = emit_last;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = i_next;
                        n_state = S_LOOK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Per-operation working registers.
    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_pos  <= n_pos;
        r_i    <= n_i;
        r_n    <= n_n;
        r_ok   <= n_ok;
        r_fv   <= n_fv;
        r_rd   <= n_rd;
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_count    = r_count;

`ifndef SYNTHESIS
    // The list never holds more than the full depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    // A result is only issued into a free output slot.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit.valid |-> i_out_free)
        else $error("result issued into a busy output register");

    // Append only happens with room left in the store.
    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |-> (r_count < CW'(DEPTH)))
        else $error("append into a full store");

    // A shift write always lands inside the occupied range.
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SH_WR) |-> (i_next < r_count))
        else $error("shift write outside the list");

    // A transfer on the input always starts decoding in the next cycle.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted item not decoded");
`endif

endmodule

### dv/lru_ordered_key_list_top_tb.sv
// ----------------------------------------------------------------------------
// LRU ordered key list testbench
// Drives put, hit, remove, remove/read at position and clear transfers into
// the block and checks every result transfer against a shadow copy of the
// key list. A short directed sequence comes first. Random phases follow, each
// under its own capacity limit, with random idling on both channels.
// ----------------------------------------------------------------------------
module lru_ordered_key_list_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = 16;
    localparam int CYCLE_LIMIT = 300000;

    // One operation on the list, as sent on the input channel.
    typedef struct {
        logic [2:0]  func;
        logic [31:0] key;
        logic [3:0]  position;
        bit          drain_first;
    } t_list_op;

    // One result, as seen on the output channel.
    typedef struct {
        logic        ok;
        logic        freed_valid;
        logic [31:0] freed_key;
        logic [31:0] read_key;
        logic [4:0]  count;
        logic        last;
    } t_list_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_ready;
    logic [2:0]  func = lrukl_pkg::FUNC_PUT;
    logic [31:0] key = '0;
    logic [3:0]  position = '0;
    logic        o_out_valid;
    logic        out_ready = 1'b0;
    logic        o_ok;
    logic        o_freed_valid;
    logic [31:0] o_freed_key;
    logic [31:0] o_read_key;
    logic [4:0]  o_count;
    logic        o_last;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_data = '0;

    // Operations waiting to be sent and results waiting to arrive.
    t_list_op     op_queue[$];
    t_list_result expected_results[$];
    t_list_op     cur_op;

    // Shadow copy of the key list and of the capacity register.
    logic [31:0] shadow_keys[LIST_DEPTH];
    int          shadow_count = 0;
    int          shadow_limit = 0;

    // Keys that random operations mostly draw from, so that hits and removes find
    // something.
    logic [31:0] key_pool[8];

    int tx_idle_pct = 15;
    int rx_idle_pct = 15;
    int fail_count = 0;
    int cycle_count = 0;

    lru_ordered_key_list_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (func),
        .i_key         (key),
        .i_position    (position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_ok          (o_ok),
        .o_freed_valid (o_freed_valid),
        .o_freed_key   (o_freed_key),
        .o_read_key    (o_read_key),
        .o_count       (o_count),
        .o_last        (o_last),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Remove the shadow entry at idx and close the gap behind it.
    function automatic logic [31:0] shadow_take(input int idx);
        logic [31:0] taken;
        taken = shadow_keys[idx];
        for (int i = idx; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
        end
        shadow_count--;
        return taken;
    endfunction

    function automatic int shadow_find(input logic [31:0] k);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_keys[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Apply one accepted operation to the shadow list and queue the results it
    // must produce.
    function automatic void list_apply(input t_list_op op);
        t_list_result res;
        int           idx;
        int           cap;
        int           n;
        logic [31:0]  moved;
        res = '{ok: 1'b0, freed_valid: 1'b0, freed_key: '0, read_key: '0,
                count: '0, last: 1'b1};
        case (op.func)
            lrukl_pkg::FUNC_PUT: begin
                cap = (shadow_limit == 0 || shadow_limit > LIST_DEPTH) ?
                      LIST_DEPTH : shadow_limit;
                if (shadow_count == cap || shadow_count >= LIST_DEPTH) begin
                    res.freed_valid = 1'b1;
                    res.freed_key   = shadow_take(0);
                end
                shadow_keys[shadow_count] = op.key;
                shadow_count++;
                res.ok = 1'b1;
            end
            lrukl_pkg::FUNC_HIT: begin
                idx = shadow_find(op.key);
                if (idx >= 0) begin
                    // The hit key goes to the newest end after the gap closes.
                    moved                     = shadow_take(idx);
                    shadow_keys[shadow_count] = moved;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            lrukl_pkg::FUNC_REMOVE: begin
                idx = shadow_find(op.key);
                if (idx >= 0) begin
                    res.ok          = 1'b1;
                    res.freed_valid = 1'b1;
                    res.freed_key   = shadow_take(idx);
                end
            end
            lrukl_pkg::FUNC_REMOVE_AT: begin
                if (int'(op.position) < shadow_count) begin
                    res.ok          = 1'b1;
                    res.freed_valid = 1'b1;
                    res.freed_key   = shadow_take(int'(op.position));
                end
            end
            lrukl_pkg::FUNC_READ_AT: begin
                if (int'(op.position) < shadow_count) begin
                    res.ok       = 1'b1;
                    res.read_key = shadow_keys[op.position];
                end
            end
            lrukl_pkg::FUNC_CLEAR: begin
                n            = shadow_count;
                shadow_count = 0;
                res.ok       = 1'b1;
                if (n > 0) begin
                    // Every stored key comes back, oldest first.
                    res.freed_valid = 1'b1;
                    for (int i = 0; i < n; i++) begin
                        res.freed_key = shadow_keys[i];
                        res.last      = (i == n - 1);
                        expected_results.push_back(res);
                    end
                    return;
                end
            end
            default: ;
        endcase
        res.count = shadow_count[4:0];
        expected_results.push_back(res);
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Driver: presents the next pending operation once the current transfer is
    // done, with random idle cycles in between.
    always @(posedge i_clk) begin
        bit       fire;
        bit       go;
        t_list_op nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            fire = in_valid && o_in_ready;
            if (fire) begin
                list_apply(cur_op);
            end
            if (!in_valid || fire) begin
                go = (op_queue.size() > 0) && ($urandom_range(99) >= tx_idle_pct);
                // Some operations hold back until every result has come back.
                if (go && op_queue[0].drain_first && expected_results.size() > 0) begin
                    go = 1'b0;
                end
                if (go) begin
                    nxt      = op_queue.pop_front();
                    cur_op   = nxt;
                    in_valid <= 1'b1;
                    func     <= nxt.func;
                    key      <= nxt.key;
                    position <= nxt.position;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation and
    // stalls the output channel at random.
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no expectation pending");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    fail_count += field_mismatch("ok", 32'(want.ok), 32'(o_ok));
                    fail_count += field_mismatch("freed_valid", 32'(want.freed_valid),
                                                 32'(o_freed_valid));
                    fail_count += field_mismatch("freed_key", want.freed_key, o_freed_key);
                    fail_count += field_mismatch("read_key", want.read_key, o_read_key);
                    fail_count += field_mismatch("count", 32'(want.count), 32'(o_count));
                    fail_count += field_mismatch("last", 32'(want.last), 32'(o_last));
                end
            end
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_list_op make_op(input logic [2:0] f, input logic [31:0] k,
                                         input logic [3:0] p);
        return '{func: f, key: k, position: p, drain_first: 1'b0};
    endfunction

    // Wait until nothing is pending, then let the block settle.
    task automatic wait_idle();
        while (op_queue.size() > 0 || in_valid || expected_results.size() > 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [4:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        shadow_limit = int'(value);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 80) begin
            return key_pool[$urandom_range(7)];
        end
        return $urandom;
    endfunction

    // Queue one random phase with the given share of puts.
    task automatic queue_random_phase(input int n, input int put_pct);
        t_list_op op;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 8; i++) begin
            key_pool[i] = $urandom;
        end
        for (int i = 0; i < n; i++) begin
            op = make_op(lrukl_pkg::FUNC_PUT, pick_key(), 4'($urandom_range(15)));
            if ($urandom_range(99) >= put_pct) begin
                case ($urandom_range(15)) inside
                    0:          op.func = lrukl_pkg::FUNC_CLEAR;
                    1, 2, 3, 4: op.func = lrukl_pkg::FUNC_HIT;
                    5, 6, 7:    op.func = lrukl_pkg::FUNC_REMOVE;
                    8, 9, 10:   op.func = lrukl_pkg::FUNC_REMOVE_AT;
                    default:    op.func = lrukl_pkg::FUNC_READ_AT;
                endcase
            end
            // One operation in the middle of every phase always waits for a drain.
            op.drain_first = (i == n / 2) || ($urandom_range(24) == 0);
            op_queue.push_back(op);
        end
    endtask

    // Stimulus sequence.
    initial begin
        int phase_limit[7];
        int phase_puts[7];
        phase_limit = '{16, 3, 31, 0, 1, 9, 2};
        phase_puts  = '{60, 45, 70, 80, 40, 55, 50};
        for (int i = 0; i < LIST_DEPTH; i++) begin
            shadow_keys[i] = '0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_limit(5'd0);

        // Empty list, missing keys, duplicates, first-match hit and positions
        // out of range.
        op_queue.push_back(make_op(lrukl_pkg::FUNC_CLEAR, '0, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_READ_AT, '0, 4'd0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_HIT, 32'd5, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_REMOVE, 32'd5, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, '0, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, '1, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, 32'h5A5A_A5A5, '1));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, '1, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_HIT, '1, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_READ_AT, '0, 4'd2));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_READ_AT, '0, 4'd15));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_REMOVE, '1, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_REMOVE_AT, '0, 4'd1));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_REMOVE_AT, '0, 4'd15));
        wait_idle();

        // Limit lowered below the count: puts append until a clear, then
        // evict at the limit.
        write_limit(5'd1);
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, 32'h0000_00A1, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, 32'h0000_00B2, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_CLEAR, '0, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, 32'h8000_0001, '0));
        op_queue.push_back(make_op(lrukl_pkg::FUNC_PUT, 32'h7FFF_FFFE, '0));
        wait_idle();

        // Random phases, each under a different limit; one runs with no idling.
        for (int p = 0; p < 7; p++) begin
            write_limit(5'(phase_limit[p]));
            tx_idle_pct = (p == 2) ? 0 : 15;
            rx_idle_pct = (p == 2) ? 0 : 15;
            queue_random_phase(12, phase_puts[p]);
            wait_idle();
        end

        repeat (40) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
